FILE: rtl/core/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Codes, widths and the per-slot record shared by the tick process scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

	// Item actions
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Scheduling algorithms
	localparam logic [1:0] ALG_RR   = 2'd0;
	localparam logic [1:0] ALG_FCFS = 2'd1;
	localparam logic [1:0] ALG_SJF  = 2'd2;

	// Slot status codes
	localparam logic [1:0] ST_READY   = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_DONE    = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ALGORITHM     = 2'd0;
	localparam logic [1:0] CFG_PROCESS_COUNT = 2'd1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int ACTION_W   = 2;
	localparam int SLOT_W     = 4;
	localparam int BURST_W    = 16;
	localparam int TIME_W     = 32;
	localparam int ALG_W      = 2;
	localparam int COUNT_W    = 5;

	localparam logic [BURST_W-1:0] EXEC_MAX = 16'hFFFF;

	// Per-slot record kept in the slot state memory; all zero is the reset value.
	typedef struct packed {
		logic [1:0]         status;
		logic [BURST_W-1:0] executed;
		logic [TIME_W-1:0]  arrival;
	} tps_entry_t;

endpackage

FILE: rtl/core/tps_ram.sv
// ----------------------------------------------------------------------------
// tps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tick_process_scheduler.sv
// ----------------------------------------------------------------------------
// tick_process_scheduler
// Tick-driven round-robin / FCFS / SJF scheduler over a ring of process slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | action, slot, burst
//  out     | out       | out_valid/out_ready  | running_valid .. total_turnaround
//
// A load item goes straight to the output; a start item writes one entry per
// ring slot. A tick that charges a slot passes read, charge and finish, and a
// switch adds a scan that reads one slot state entry per cycle.
// Reset clears one valid flag per slot, so no clearing pass is needed.
// The result is held in an output register; a new item is taken while it waits,
// and the block stalls only when the next result is ready and the first is not taken.
module tick_process_scheduler #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tps_pkg::ACTION_W-1:0]    action,
	input  logic [tps_pkg::SLOT_W-1:0]      slot,
	input  logic [tps_pkg::BURST_W-1:0]     burst,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            running_valid,
	output logic [tps_pkg::SLOT_W-1:0]      running_slot,
	output logic                            switched,
	output logic                            finished_valid,
	output logic [tps_pkg::SLOT_W-1:0]      finished_slot,
	output logic [tps_pkg::TIME_W-1:0]      turnaround,
	output logic [tps_pkg::TIME_W-1:0]      wait_ticks,
	output logic                            all_done,
	output logic [tps_pkg::TIME_W-1:0]      total_wait,
	output logic [tps_pkg::TIME_W-1:0]      total_turnaround
);

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int NW = $clog2(MAX_SLOTS + 1);
	localparam int EW = $bits(tps_pkg::tps_entry_t);
	localparam int TW = tps_pkg::TIME_W;
	localparam int BW = tps_pkg::BURST_W;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_START = 10'b0000000010,
		S_RD    = 10'b0000000100,
		S_CHG   = 10'b0000001000,
		S_FIN   = 10'b0000010000,
		S_ACC   = 10'b0000100000,
		S_SCAN  = 10'b0001000000,
		S_NXRD  = 10'b0010000000,
		S_NXWR  = 10'b0100000000,
		S_EMIT  = 10'b1000000000
	} state_t;

	// Ring successor of s in a ring of n slots.
	function automatic logic [SW-1:0] succ(input logic [SW-1:0] s, input logic [NW-1:0] n);
		logic [NW-1:0] t;
		t = NW'(s) + NW'(1);
		return (t >= n) ? '0 : t[SW-1:0];
	endfunction

	// Control state
	state_t                        state_q;
	logic [tps_pkg::ALG_W-1:0]     algorithm_q;
	logic [tps_pkg::COUNT_W-1:0]   pcount_q;
	logic                          active_q;
	logic [SW-1:0]                 cur_q;
	logic [NW-1:0]                 fcnt_q;
	logic [TW-1:0]                 tick_q;
	logic [TW-1:0]                 wait_sum_q;
	logic [TW-1:0]                 tat_sum_q;
	logic [MAX_SLOTS-1:0]          valid_q;
	logic [NW-1:0]                 cnt_q;
	logic                          scan_pend_s1;
	logic                          found_q;
	logic                          halt_q;
	logic                          sw_q;
	logic                          out_valid_q;
	logic                          vld_rd_s1;

	// Payload registers
	logic [SW-1:0]                 scan_addr_q;
	logic [SW-1:0]                 scan_idx_s1;
	logic [SW-1:0]                 best_q;
	logic [BW-1:0]                 best_burst_q;
	logic [1:0]                    st_s2;
	logic [BW-1:0]                 exec_s2;
	logic [TW-1:0]                 arr_s2;
	logic [BW-1:0]                 burst_s2;
	logic                          term_s2;
	logic [TW-1:0]                 tat_s2;
	logic                          res_switched_q;
	logic                          res_fin_q;
	logic [SW-1:0]                 res_fin_slot_q;
	logic [TW-1:0]                 res_tat_q;
	logic [TW-1:0]                 res_wt_q;
	logic                          res_all_done_q;
	logic [TW-1:0]                 res_tw_q;
	logic [TW-1:0]                 res_tt_q;
	logic                          out_run_valid_q;
	logic [tps_pkg::SLOT_W-1:0]    out_run_slot_q;
	logic                          out_switched_q;
	logic                          out_fin_valid_q;
	logic [tps_pkg::SLOT_W-1:0]    out_fin_slot_q;
	logic [TW-1:0]                 out_tat_q;
	logic [TW-1:0]                 out_wt_q;
	logic                          out_all_done_q;
	logic [TW-1:0]                 out_tw_q;
	logic [TW-1:0]                 out_tt_q;

	// Combinational signals
	logic                          in_accept;
	logic                          emit_load;
	logic [31:0]                   n_full;
	logic [NW-1:0]                 ring_n;
	logic [31:0]                   slot_ext;
	logic [31:0]                   cur_ext;
	logic [31:0]                   fin_slot_ext;
	logic                          burst_we;
	logic [SW-1:0]                 rd_addr;
	logic [BW-1:0]                 burst_rdata;
	logic [EW-1:0]                 ent_rdata;
	tps_pkg::tps_entry_t           ent_rd;
	logic                          ent_we;
	logic [SW-1:0]                 ent_waddr;
	tps_pkg::tps_entry_t           ent_wdata;
	logic                          chg_running;
	logic [BW-1:0]                 chg_exec;
	logic                          chg_term;
	logic [TW-1:0]                 chg_tat;
	logic [TW-1:0]                 fin_wt;
	logic [NW-1:0]                 fin_fcnt;
	logic                          fin_halt;
	logic [1:0]                    fin_status;
	logic                          fin_sw;
	logic [1:0]                    fin_status_wr;
	logic                          is_sjf;
	logic                          scan_issue;
	logic                          scan_hit;
	logic                          scan_done;
	logic [SW-1:0]                 scan_next;
	logic                          scan_start;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign n_full = (32'(pcount_q) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : 32'(pcount_q);
	assign ring_n = n_full[NW-1:0];

	assign slot_ext     = 32'(slot);
	assign cur_ext      = 32'(cur_q);
	assign fin_slot_ext = 32'(res_fin_slot_q);

	// Loads go straight into the burst memory at acceptance.
	assign burst_we = in_accept && (action == tps_pkg::ACT_LOAD)
		&& (slot_ext < 32'(MAX_SLOTS));

	assign rd_addr = (state_q == S_SCAN) ? scan_addr_q : cur_q;

	tps_ram #(
		.WIDTH(BW),
		.DEPTH(MAX_SLOTS)
	) u_burst_ram (
		.clk  (clk),
		.we   (burst_we),
		.waddr(slot_ext[SW-1:0]),
		.wdata(burst),
		.raddr(rd_addr),
		.rdata(burst_rdata)
	);

	tps_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(rd_addr),
		.rdata(ent_rdata)
	);

	// A slot never written since reset reads as ready with zero time.
	assign ent_rd = vld_rd_s1 ? tps_pkg::tps_entry_t'(ent_rdata) : '0;

	// Charge stage
	assign chg_running = (ent_rd.status == tps_pkg::ST_RUNNING);
	assign chg_exec    = (chg_running && (ent_rd.executed != tps_pkg::EXEC_MAX))
		? ent_rd.executed + BW'(1) : ent_rd.executed;
	assign chg_term    = chg_running && (chg_exec >= burst_rdata);
	assign chg_tat     = tick_q - ent_rd.arrival;

	// Finish stage
	assign fin_wt     = tat_s2 - TW'(burst_s2);
	assign fin_fcnt   = fcnt_q + NW'(1);
	assign fin_halt   = term_s2 && (fin_fcnt >= ring_n);
	assign fin_status = term_s2 ? tps_pkg::ST_DONE : st_s2;
	assign fin_sw     = !fin_halt
		&& ((fin_status == tps_pkg::ST_DONE) || (algorithm_q == tps_pkg::ALG_RR));
	assign fin_status_wr = (fin_sw && (fin_status == tps_pkg::ST_RUNNING))
		? tps_pkg::ST_READY : fin_status;

	// Slot scan: one read issued per cycle, evaluated in the next cycle.
	assign is_sjf     = (algorithm_q == tps_pkg::ALG_SJF);
	assign scan_issue = (cnt_q < ring_n);
	assign scan_hit   = is_sjf
		? ((ent_rd.status == tps_pkg::ST_READY) && (!found_q || (burst_rdata < best_burst_q)))
		: (!found_q && (ent_rd.status != tps_pkg::ST_DONE));
	assign scan_done  = (!scan_issue && !scan_pend_s1) || (!is_sjf && found_q);
	assign scan_next  = found_q ? best_q : succ(cur_q, ring_n);
	assign scan_start = ((state_q == S_FIN) && !term_s2 && fin_sw)
		|| ((state_q == S_ACC) && sw_q);

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = cur_q;
		ent_wdata = '0;
		unique case (state_q)
			S_START: begin
				ent_we             = 1'b1;
				ent_waddr          = cnt_q[SW-1:0];
				ent_wdata.status   = (cnt_q == '0) ? tps_pkg::ST_RUNNING : tps_pkg::ST_READY;
				ent_wdata.executed = '0;
				ent_wdata.arrival  = tick_q;
			end
			S_FIN: begin
				ent_we             = 1'b1;
				ent_wdata.status   = fin_status_wr;
				ent_wdata.executed = exec_s2;
				ent_wdata.arrival  = arr_s2;
			end
			S_NXWR: begin
				ent_we             = 1'b1;
				ent_wdata.status   = tps_pkg::ST_RUNNING;
				ent_wdata.executed = ent_rd.executed;
				ent_wdata.arrival  = ent_rd.arrival;
			end
			default: begin
				ent_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			algorithm_q  <= '0;
			pcount_q     <= '0;
			active_q     <= 1'b0;
			cur_q        <= '0;
			fcnt_q       <= '0;
			tick_q       <= '0;
			wait_sum_q   <= '0;
			tat_sum_q    <= '0;
			valid_q      <= '0;
			cnt_q        <= '0;
			scan_pend_s1 <= 1'b0;
			found_q      <= 1'b0;
			halt_q       <= 1'b0;
			sw_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			vld_rd_s1    <= 1'b0;
		end else begin
			vld_rd_s1 <= valid_q[rd_addr];
			if (ent_we) begin
				valid_q[ent_waddr] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tps_pkg::CFG_ALGORITHM:     algorithm_q <= cfg_data[tps_pkg::ALG_W-1:0];
					tps_pkg::CFG_PROCESS_COUNT: pcount_q    <= cfg_data[tps_pkg::COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (scan_start) begin
				cnt_q        <= '0;
				scan_pend_s1 <= 1'b0;
				found_q      <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						unique case (action)
							tps_pkg::ACT_LOAD: begin
								state_q <= S_EMIT;
							end
							tps_pkg::ACT_START: begin
								fcnt_q     <= '0;
								wait_sum_q <= '0;
								tat_sum_q  <= '0;
								cur_q      <= '0;
								cnt_q      <= '0;
								if (ring_n != '0) begin
									active_q <= 1'b1;
									state_q  <= S_START;
								end else begin
									active_q <= 1'b0;
									state_q  <= S_EMIT;
								end
							end
							tps_pkg::ACT_TICK: begin
								tick_q <= tick_q + TW'(1);
								if (active_q && (ring_n == '0)) begin
									active_q <= 1'b0;
									state_q  <= S_EMIT;
								end else if (active_q) begin
									state_q <= S_RD;
								end else begin
									state_q <= S_EMIT;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_START: begin
					cnt_q <= cnt_q + NW'(1);
					if ((cnt_q + NW'(1)) == ring_n) begin
						state_q <= S_EMIT;
					end
				end
				S_RD: begin
					state_q <= S_CHG;
				end
				S_CHG: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					halt_q <= fin_halt;
					sw_q   <= fin_sw;
					if (term_s2) begin
						fcnt_q  <= fin_fcnt;
						state_q <= S_ACC;
						if (fin_halt) begin
							active_q <= 1'b0;
						end
					end else if (fin_sw) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_ACC: begin
					wait_sum_q <= wait_sum_q + res_wt_q;
					tat_sum_q  <= tat_sum_q + res_tat_q;
					state_q    <= sw_q ? S_SCAN : S_EMIT;
				end
				S_SCAN: begin
					scan_pend_s1 <= scan_issue;
					if (scan_issue) begin
						cnt_q <= cnt_q + NW'(1);
					end
					if (scan_pend_s1 && scan_hit) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						cur_q   <= scan_next;
						state_q <= S_NXRD;
					end
				end
				S_NXRD: begin
					state_q <= S_NXWR;
				end
				S_NXWR: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_switched_q <= 1'b0;
			res_fin_q      <= 1'b0;
			res_fin_slot_q <= '0;
			res_tat_q      <= '0;
			res_wt_q       <= '0;
			res_all_done_q <= 1'b0;
			res_tw_q       <= '0;
			res_tt_q       <= '0;
		end
		if (state_q == S_CHG) begin
			st_s2    <= ent_rd.status;
			exec_s2  <= chg_exec;
			arr_s2   <= ent_rd.arrival;
			burst_s2 <= burst_rdata;
			term_s2  <= chg_term;
			tat_s2   <= chg_tat;
		end
		if (state_q == S_FIN) begin
			res_switched_q <= fin_sw;
			if (term_s2) begin
				res_fin_q      <= 1'b1;
				res_fin_slot_q <= cur_q;
				res_tat_q      <= tat_s2;
				res_wt_q       <= fin_wt;
			end
		end
		if ((state_q == S_ACC) && halt_q) begin
			res_all_done_q <= 1'b1;
			res_tw_q       <= wait_sum_q + res_wt_q;
			res_tt_q       <= tat_sum_q + res_tat_q;
		end
		if (scan_start) begin
			scan_addr_q <= is_sjf ? '0 : succ(cur_q, ring_n);
		end
		if (state_q == S_SCAN) begin
			if (scan_issue) begin
				scan_addr_q <= is_sjf ? scan_addr_q + SW'(1) : succ(scan_addr_q, ring_n);
				scan_idx_s1 <= scan_addr_q;
			end
			if (scan_pend_s1 && scan_hit) begin
				best_q       <= scan_idx_s1;
				best_burst_q <= burst_rdata;
			end
		end
		if (emit_load) begin
			out_run_valid_q <= active_q;
			out_run_slot_q  <= active_q ? cur_ext[tps_pkg::SLOT_W-1:0] : '0;
			out_switched_q  <= res_switched_q;
			out_fin_valid_q <= res_fin_q;
			out_fin_slot_q  <= fin_slot_ext[tps_pkg::SLOT_W-1:0];
			out_tat_q       <= res_tat_q;
			out_wt_q        <= res_wt_q;
			out_all_done_q  <= res_all_done_q;
			out_tw_q        <= res_tw_q;
			out_tt_q        <= res_tt_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign running_valid    = out_run_valid_q;
	assign running_slot     = out_run_slot_q;
	assign switched         = out_switched_q;
	assign finished_valid   = out_fin_valid_q;
	assign finished_slot    = out_fin_slot_q;
	assign turnaround       = out_tat_q;
	assign wait_ticks       = out_wt_q;
	assign all_done         = out_all_done_q;
	assign total_wait       = out_tw_q;
	assign total_turnaround = out_tt_q;

endmodule
